// File: rtl/alr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package alr_pkg;

    localparam int SPAN_W  = 6;
    localparam int YPOS_W  = 28;
    localparam int GRAD_W  = 18;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         opacity;
    } alr_in_t;

    typedef struct packed {
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic               neighbour_on_x;
        logic [7:0]         alpha_main;
        logic [7:0]         alpha_neighbour;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic               last;
        logic               clipped;
    } alr_out_t;

    // one line, set up for the column walk
    typedef struct packed {
        logic               steep;
        logic               clip;
        logic [11:0]        col1;
        logic [11:0]        col2;
        logic [YPOS_W-1:0]  yend1;
        logic [YPOS_W-1:0]  yend2;
        logic [YPOS_W-1:0]  grad;
        logic [12:0]        w1;
        logic [12:0]        w2;
        logic [7:0]         opacity;
        logic [SPAN_W-1:0]  inner;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } alr_desc_t;

endpackage
`default_nettype wire

// File: rtl/alr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface alr_in_if;
    logic             valid;
    logic             ready;
    alr_pkg::alr_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/alr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface alr_out_if;
    logic              valid;
    logic              ready;
    alr_pkg::alr_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/alr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module alr_front #(
    parameter int MAX_SPAN = 62
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    alr_in_if.sink             in_ch,
    input  wire logic          q_full,
    output logic               q_push,
    output alr_pkg::alr_desc_t q_data
);
    import alr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWAP  = 3'd1;
    localparam logic [2:0] S_ORDER = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CALC  = 3'd4;

    logic [2:0]         st_reg, st_next;
    logic signed [15:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [7:0]         r_reg, g_reg, b_reg, op_reg;
    logic               steep_reg, neg_reg, dxz_reg;
    logic [15:0]        dx_reg, rem_reg;
    logic [16:0]        num_reg, q_reg;
    logic [4:0]         cnt_reg;

    // swap stage
    logic signed [16:0] sdx, sdy;
    logic [16:0]        adx, ady;
    logic               steep_c;

    // order stage
    logic               flip;
    logic signed [15:0] ox1, oy1, ox2, oy2;
    logic signed [16:0] odx, ody;
    logic [15:0]        mag;
    logic [32:0]        numer;

    // divide step
    logic [16:0]        trial;
    logic               qbit;

    // endpoint stage
    logic signed [GRAD_W-1:0] grad;
    logic signed [16:0]       sum1, sum2;
    logic signed [12:0]       col1, col2;
    logic [3:0]               fr1, fr2;
    logic signed [4:0]        d1, d2;
    logic signed [22:0]       pr1, pr2;
    logic signed [18:0]       off1, off2;
    logic [YPOS_W-1:0]        yend1, yend2;
    logic [4:0]               g1;
    logic signed [13:0]       raw;
    logic                     clip;
    logic [SPAN_W-1:0]        inner;

    assign in_ch.ready = (st_reg == S_IDLE);

    assign sdx = 17'(bx_reg) - 17'(ax_reg);
    assign sdy = 17'(by_reg) - 17'(ay_reg);
    assign adx = sdx[16] ? 17'(-sdx) : 17'(sdx);
    assign ady = sdy[16] ? 17'(-sdy) : 17'(sdy);
    assign steep_c = ady > adx;

    assign flip  = ax_reg > bx_reg;
    assign ox1   = flip ? bx_reg : ax_reg;
    assign oy1   = flip ? by_reg : ay_reg;
    assign ox2   = flip ? ax_reg : bx_reg;
    assign oy2   = flip ? ay_reg : by_reg;
    assign odx   = 17'(ox2) - 17'(ox1);
    assign ody   = 17'(oy2) - 17'(oy1);
    assign mag   = ody[16] ? 16'(-ody) : 16'(ody);
    assign numer = {1'b0, mag, 16'b0} + 33'(odx[16:1]);

    assign trial = {rem_reg, num_reg[16]};
    assign qbit  = trial >= {1'b0, dx_reg};

    assign grad = dxz_reg ? GRAD_W'(65536)
                : (neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg}));

    assign sum1 = 17'(ax_reg) + 17'sd8;
    assign sum2 = 17'(bx_reg) + 17'sd8;
    assign col1 = 13'(sum1 >>> 4);
    assign col2 = 13'(sum2 >>> 4);
    assign fr1  = sum1[3:0];
    assign fr2  = sum2[3:0];
    assign d1   = 5'sd8 - $signed({1'b0, fr1});
    assign d2   = 5'sd8 - $signed({1'b0, fr2});
    assign pr1  = 23'(grad) * 23'(d1);
    assign pr2  = 23'(grad) * 23'(d2);
    assign off1 = 19'((pr1 + 23'sd8) >>> 4);
    assign off2 = 19'((pr2 + 23'sd8) >>> 4);
    assign yend1 = {ay_reg[15:0], 12'b0} + YPOS_W'(off1);
    assign yend2 = {by_reg[15:0], 12'b0} + YPOS_W'(off2);
    assign g1   = 5'd16 - {1'b0, fr1};
    assign raw  = 14'(col2) - 14'(col1) - 14'sd1;
    assign clip = raw > $signed(14'(MAX_SPAN));
    assign inner = raw[13] ? '0 : (clip ? SPAN_W'(MAX_SPAN) : SPAN_W'(raw));

    always_comb
    begin
        q_data.steep   = steep_reg;
        q_data.clip    = clip;
        q_data.col1    = col1[11:0];
        q_data.col2    = col2[11:0];
        q_data.yend1   = yend1;
        q_data.yend2   = yend2;
        q_data.grad    = YPOS_W'(grad);
        q_data.w1      = 13'(g1 * op_reg);
        q_data.w2      = 13'(fr2 * op_reg);
        q_data.opacity = op_reg;
        q_data.inner   = inner;
        q_data.red     = r_reg;
        q_data.green   = g_reg;
        q_data.blue    = b_reg;
    end

    assign q_push = (st_reg == S_CALC) && !q_full;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (in_ch.valid) st_next = S_SWAP;
            S_SWAP:  st_next = S_ORDER;
            S_ORDER: st_next = S_DIV;
            S_DIV:   if (cnt_reg == 5'd1) st_next = S_CALC;
            S_CALC:  if (!q_full) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= S_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                ax_reg <= in_ch.data.start_x;
                ay_reg <= in_ch.data.start_y;
                bx_reg <= in_ch.data.end_x;
                by_reg <= in_ch.data.end_y;
                r_reg  <= in_ch.data.red;
                g_reg  <= in_ch.data.green;
                b_reg  <= in_ch.data.blue;
                op_reg <= in_ch.data.opacity;
            end
            S_SWAP:
            begin
                steep_reg <= steep_c;
                if (steep_c)
                begin
                    ax_reg <= ay_reg;
                    ay_reg <= ax_reg;
                    bx_reg <= by_reg;
                    by_reg <= bx_reg;
                end
            end
            S_ORDER:
            begin
                ax_reg  <= ox1;
                ay_reg  <= oy1;
                bx_reg  <= ox2;
                by_reg  <= oy2;
                dx_reg  <= odx[15:0];
                dxz_reg <= (odx == 17'sd0);
                neg_reg <= ody[16];
                rem_reg <= numer[32:17];
                num_reg <= numer[16:0];
                q_reg   <= '0;
                cnt_reg <= 5'd17;
            end
            S_DIV:
            begin
                rem_reg <= qbit ? 16'(trial - {1'b0, dx_reg}) : trial[15:0];
                num_reg <= {num_reg[15:0], 1'b0};
                q_reg   <= {q_reg[15:0], qbit};
                cnt_reg <= cnt_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/alr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module alr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  alr_pkg::alr_desc_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output alr_pkg::alr_desc_t head
);
    import alr_pkg::*;

    alr_desc_t   mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> !pop) else $error("queue pop while empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: rtl/alr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module alr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_valid,
    input  alr_pkg::alr_desc_t q_head,
    output logic               q_pop,
    alr_out_if.source          out_ch
);
    import alr_pkg::*;

    localparam logic [1:0] P_EP1   = 2'd0;
    localparam logic [1:0] P_INNER = 2'd1;
    localparam logic [1:0] P_EP2   = 2'd2;

    logic [1:0]        phase_reg;
    logic [YPOS_W-1:0] inter_reg;
    logic [11:0]       col_reg;
    logic [SPAN_W-1:0] cnt_reg;
    logic              ov_reg;
    alr_out_t          od_reg;

    logic              adv;
    logic [YPOS_W-1:0] ypos;
    logic [11:0]       col, row;
    logic [12:0]       w;
    logic [16:0]       cov;
    logic [29:0]       pm, pn;

    assign adv = q_valid && (!ov_reg || out_ch.ready);
    assign q_pop = adv && (phase_reg == P_EP2);

    always_comb
    begin
        case (phase_reg)
            P_EP1:
            begin
                ypos = q_head.yend1;
                col  = q_head.col1;
                w    = q_head.w1;
            end
            P_INNER:
            begin
                ypos = inter_reg;
                col  = col_reg;
                w    = {1'b0, q_head.opacity, 4'b0};
            end
            default:
            begin
                ypos = q_head.yend2;
                col  = q_head.col2;
                w    = q_head.w2;
            end
        endcase
    end

    assign row = ypos[27:16];
    assign cov = 17'd65536 - {1'b0, ypos[15:0]};
    assign pm  = 30'(cov) * 30'(w);
    assign pn  = 30'(ypos[15:0]) * 30'(w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_EP1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (adv)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
            if (adv)
            begin
                case (phase_reg)
                    P_EP1:   phase_reg <= (q_head.inner == '0) ? P_EP2 : P_INNER;
                    P_INNER: if (cnt_reg == SPAN_W'(1)) phase_reg <= P_EP2;
                    default: phase_reg <= P_EP1;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            od_reg.pixel_x         <= q_head.steep ? row : col;
            od_reg.pixel_y         <= q_head.steep ? col : row;
            od_reg.neighbour_on_x  <= q_head.steep;
            od_reg.alpha_main      <= pm[27:20];
            od_reg.alpha_neighbour <= pn[27:20];
            od_reg.out_red         <= q_head.red;
            od_reg.out_green       <= q_head.green;
            od_reg.out_blue        <= q_head.blue;
            od_reg.last            <= (phase_reg == P_EP2);
            od_reg.clipped         <= q_head.clip;
            if (phase_reg == P_EP1)
            begin
                inter_reg <= q_head.yend1 + q_head.grad;
                col_reg   <= q_head.col1 + 12'd1;
                cnt_reg   <= q_head.inner;
            end
            else
            begin
                inter_reg <= inter_reg + q_head.grad;
                col_reg   <= col_reg + 12'd1;
                cnt_reg   <= cnt_reg - SPAN_W'(1);
            end
        end
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

`ifndef SYNTHESIS
    a_inner_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == P_INNER |-> cnt_reg != '0) else $error("inner walk with zero count");
    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_ch.valid && out_ch.data.last) else $error("pop without last item");
    a_skip_inner: assert property (@(posedge clk) disable iff (!rst_n)
        adv && phase_reg == P_EP1 && q_head.inner == '0 |=> phase_reg == P_EP2)
        else $error("empty inner span not skipped");
`endif

endmodule
`default_nettype wire

// File: rtl/antialiased_line_rasterizer_top.sv
// Antialiased line unit: one item is a segment with signed 12.4 endpoints, a color and an
// opacity; it returns two to MAX_SPAN+2 pixel-pair items, first endpoint column, inner columns,
// then the second endpoint column (last set). The front end sets up one line at a time, mostly
// in the 17-step gradient divider; the back end emits one pair per cycle while a line is queued
// and the output is not stalled. A two-entry line queue lets the next line be set up while the
// current one is walked; the output pairs are registered.
`timescale 1ns / 1ps
`default_nettype none
module antialiased_line_rasterizer_top #(
    parameter int MAX_SPAN = 62
) (
    input  wire logic clk,
    input  wire logic rst_n,
    alr_in_if.sink    in_ch,
    alr_out_if.source out_ch
);
    import alr_pkg::*;

    logic      push, full, pop, head_valid;
    alr_desc_t push_data, head;

    alr_front #(.MAX_SPAN(MAX_SPAN)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (full),
        .q_push (push),
        .q_data (push_data)
    );

    alr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    alr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_head  (head),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule
`default_nettype wire

// File: dv/alr_tb_if.sv
`timescale 1ns / 1ps
// The channel interfaces live with the RTL; this file carries the shared testbench types.
package alr_tb_pkg;
    import alr_pkg::*;

    typedef struct {
        alr_in_t  line;
        bit       has_first;
        alr_out_t first_pair;
    } line_row_t;
endpackage

// File: dv/antialiased_line_rasterizer_top_tb.sv
`timescale 1ns / 1ps
module antialiased_line_rasterizer_top_tb;
    import alr_pkg::*;
    import alr_tb_pkg::*;

    localparam int MAX_SPAN   = 62;
    localparam int QONE       = 65536;
    localparam int QHALF      = 32768;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    alr_in_if  in_ch ();
    alr_out_if out_ch ();

    antialiased_line_rasterizer_top #(.MAX_SPAN(MAX_SPAN)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #6 clk = ~clk;

    alr_out_t pair_queue[$];
    alr_out_t first_pair_check[$];
    bit       first_pair_known[$];
    bit       next_is_first = 1'b1;
    int       mismatches = 0;
    int       idle_cycles = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;

    function automatic longint floor_q16(longint v);
        if (v >= 0)
            return v / QONE;
        return -((-v + QONE - 1) / QONE);
    endfunction

    function automatic alr_out_t make_pair(bit steep, longint col, longint row,
                                           longint am, longint an, alr_in_t ln,
                                           bit is_last, bit clip);
        alr_out_t p;
        p.pixel_x         = steep ? row[11:0] : col[11:0];
        p.pixel_y         = steep ? col[11:0] : row[11:0];
        p.neighbour_on_x  = steep;
        p.alpha_main      = am[7:0];
        p.alpha_neighbour = an[7:0];
        p.out_red         = ln.red;
        p.out_green       = ln.green;
        p.out_blue        = ln.blue;
        p.last            = is_last;
        p.clipped         = clip;
        return p;
    endfunction

    // Walk one segment and queue every pixel pair it produces.
    task automatic rasterize_line(alr_in_t ln);
        longint ax, ay, bx, by, t, dx, dy, dxa, dya, grad, mag, x0, y0, x1, y1;
        longint col1, col2, yend1, yend2, inter, inner;
        longint gap1, gap2, fy, op;
        bit steep, clip;
        ax = ln.start_x; ay = ln.start_y; bx = ln.end_x; by = ln.end_y;
        op = ln.opacity;
        dxa = bx - ax; dya = by - ay;
        if (dxa < 0) dxa = -dxa;
        if (dya < 0) dya = -dya;
        steep = dya > dxa;
        if (steep)
        begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dx = bx - ax;
        dy = by - ay;
        if (dx == 0)
            grad = QONE;
        else
        begin
            mag = (dy < 0) ? -dy : dy;
            mag = ((mag << 16) + dx / 2) / dx;
            grad = (dy < 0) ? -mag : mag;
        end
        x0 = ax * 4096; y0 = ay * 4096; x1 = bx * 4096; y1 = by * 4096;
        col1  = floor_q16(x0 + QHALF);
        yend1 = y0 + floor_q16(grad * (col1 * QONE - x0) + QHALF);
        gap1  = QONE - ((x0 + QHALF) & (QONE - 1));
        col2  = floor_q16(x1 + QHALF);
        yend2 = y1 + floor_q16(grad * (col2 * QONE - x1) + QHALF);
        gap2  = (x1 + QHALF) & (QONE - 1);
        inner = col2 - col1 - 1;
        if (inner < 0) inner = 0;
        clip = inner > MAX_SPAN;
        if (clip) inner = MAX_SPAN;
        fy = yend1 & (QONE - 1);
        pair_queue.insert(pair_queue.size(), make_pair(steep, col1, floor_q16(yend1),
            ((QONE - fy) * gap1 * op) >>> 32, (fy * gap1 * op) >>> 32, ln, 1'b0, clip));
        inter = yend1 + grad;
        for (longint i = 0; i < inner; i++)
        begin
            fy = inter & (QONE - 1);
            pair_queue.insert(pair_queue.size(), make_pair(steep, col1 + 1 + i,
                floor_q16(inter), ((QONE - fy) * op) >>> 16, (fy * op) >>> 16, ln,
                1'b0, clip));
            inter += grad;
        end
        fy = yend2 & (QONE - 1);
        pair_queue.insert(pair_queue.size(), make_pair(steep, col2, floor_q16(yend2),
            ((QONE - fy) * gap2 * op) >>> 32, (fy * gap2 * op) >>> 32, ln, 1'b1, clip));
    endtask

    function automatic alr_in_t mk(int sx, int sy, int ex, int ey, int r, int g, int b, int o);
        alr_in_t ln;
        ln.start_x = 16'(sx); ln.start_y = 16'(sy); ln.end_x = 16'(ex); ln.end_y = 16'(ey);
        ln.red = 8'(r); ln.green = 8'(g); ln.blue = 8'(b); ln.opacity = 8'(o);
        return ln;
    endfunction

    function automatic alr_out_t pair_of(int px, int py, bit nx, int am, int an,
                                         int r, int g, int b, bit lst, bit clp);
        alr_out_t p;
        p.pixel_x = 12'(px); p.pixel_y = 12'(py); p.neighbour_on_x = nx;
        p.alpha_main = 8'(am); p.alpha_neighbour = 8'(an);
        p.out_red = 8'(r); p.out_green = 8'(g); p.out_blue = 8'(b);
        p.last = lst; p.clipped = clp;
        return p;
    endfunction

    task automatic send_line(alr_in_t ln, bit has_first, alr_out_t first_pair);
        in_ch.valid <= 1'b1;
        in_ch.data  <= ln;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        rasterize_line(ln);
        first_pair_known.insert(first_pair_known.size(), has_first);
        first_pair_check.insert(first_pair_check.size(), first_pair);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic alr_in_t random_line();
        alr_in_t ln;
        int sx, sy, len;
        ln = {$urandom, $urandom, $urandom};
        case ($urandom_range(9))
            0, 1:
            begin
                // raw noise, usually clipped
            end
            2:
            begin
                // long line near the span limit
                sx = $signed(ln.start_x) / 2;
                sy = $signed(ln.start_y) / 2;
                ln.end_x = 16'(sx + $urandom_range(900, 1100) - ($urandom_range(1) * 2000));
                ln.end_y = 16'(sy + $urandom_range(0, 1000) - 500);
                ln.start_x = 16'(sx); ln.start_y = 16'(sy);
                if ($urandom_range(1)) {ln.start_x, ln.start_y, ln.end_x, ln.end_y} =
                    {ln.start_y, ln.start_x, ln.end_y, ln.end_x};
            end
            default:
            begin
                len = $urandom_range(0, 400);
                sx = $signed(ln.start_x) / 2;
                sy = $signed(ln.start_y) / 2;
                ln.start_x = 16'(sx); ln.start_y = 16'(sy);
                ln.end_x = 16'(sx + $urandom_range(0, 2 * len) - len);
                ln.end_y = 16'(sy + $urandom_range(0, 2 * len) - len);
            end
        endcase
        return ln;
    endfunction

    // Check pairs as they leave the block.
    always @(posedge clk)
    begin
        alr_out_t want;
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pair_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pair %p", out_ch.data);
            end
            else
            begin
                want = pair_queue.pop_front();
                if (next_is_first && first_pair_known.size() > 0)
                begin
                    if (first_pair_known[0] && first_pair_check[0] != want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("table row disagrees: table %p predicted %p",
                                     first_pair_check[0], want);
                    end
                    void'(first_pair_known.pop_front());
                    void'(first_pair_check.pop_front());
                end
                next_is_first = want.last;
                if (out_ch.data !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pair mismatch: expected %p got %p", want, out_ch.data);
                end
            end
        end
    end

    // Watchdog on stalled handshakes.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    line_row_t line_table[$];
    alr_out_t  none_pair;

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
        none_pair    = '0;
        // single point on a pixel center: gap 0.5 at both ends, opacity full
        line_table.insert(line_table.size(), '{mk(16, 16, 16, 16, 1, 2, 3, 255), 1'b1,
                          pair_of(1, 1, 1'b0, 127, 0, 1, 2, 3, 1'b0, 1'b0)});
        // zero opacity gives zero alpha
        line_table.insert(line_table.size(), '{mk(0, 0, 160, 0, 255, 255, 255, 0), 1'b1,
                          pair_of(0, 0, 1'b0, 0, 0, 255, 255, 255, 1'b0, 1'b0)});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 160, 80, 9, 8, 7, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 80, 160, 9, 8, 7, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(160, 80, 0, 0, 9, 8, 7, 200), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 160, 160, 0, 0, 0, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 160, -160, 0, 0, 0, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(3, 5, 11, 13, 10, 20, 30, 128), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 1007, 10, 1, 1, 1, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 1008, 10, 1, 1, 1, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(0, 0, 1024, 10, 1, 1, 1, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(-32768, -32768, 32767, 32767, 255, 0, 255, 255),
                            1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(32767, -32768, -32768, 32767, 0, 255, 0, 255),
                            1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(32767, 32767, 32767, 32767, 255, 255, 255, 255),
                            1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(-32768, 0, -32768, 40, 0, 0, 0, 1), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(-7, -9, -30, 25, 77, 88, 99, 254), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(8, 8, 24, 8, 1, 2, 3, 255), 1'b0, none_pair});
        line_table.insert(line_table.size(),
                          '{mk(-8, 0, 7, 15, 1, 2, 3, 255), 1'b0, none_pair});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 51;
        foreach (line_table[i])
            send_line(line_table[i].line, line_table[i].has_first, line_table[i].first_pair);
        for (int i = 0; i < 310; i++)
        begin
            if (i == 100)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 20;
            end
            else if (i == 200)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_line(random_line(), 1'b0, none_pair);
        end
        in_ch.valid <= 1'b0;

        while (pair_queue.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/alr_pkg.sv
rtl/alr_in_if.sv
rtl/alr_out_if.sv
rtl/alr_front.sv
rtl/alr_queue.sv
rtl/alr_back.sv
rtl/antialiased_line_rasterizer_top.sv
dv/alr_tb_if.sv
dv/antialiased_line_rasterizer_top_tb.sv
